// ===== hw/rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and codes for the reversible byte deque.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // Default number of byte entries in the circular store
    localparam int unsigned DEPTH_DEFAULT = 1024;

    // Command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_REVERSE = 2'd1;
    localparam logic [1:0] CMD_POP     = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Command word
    typedef struct packed {
        logic [1:0] command;
        logic       side;
        logic [7:0] data_byte;
    } rcd_in_t;

    // Response word
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       now_empty;
    } rcd_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // take the command word, update pointers
        logic load_imm;  // load response register with immediate result
        logic load_mem;  // load response register with store read data
    } rcd_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_read;  // presented word is a pop that reads the store
    } rcd_sts_t;

endpackage

// ===== hw/rtl/reversible_char_deque.sv =====
// ----------------------------------------------------------------------------
// reversible_char_deque
// Byte deque in a circular store with constant-time lazy reversal.
// ----------------------------------------------------------------------------
// Each command word (push front/back, reverse, pop front) returns exactly one
// response word. Push, reverse, failed pops and unused codes load the response
// register at acceptance; a successful pop first reads the byte store through
// its registered read port and loads the response register from the read data.
// A new command is taken when the response register is empty or its word is
// accepted in the same cycle. No command is taken during the read phase of a
// pop, which lasts until the response register can take the read byte. With
// no stalls this gives one word per cycle for all but successful pops. The
// store has no reset or clearing pass: the fill count guarantees that only
// written entries are read.
module reversible_char_deque #(
    parameter int unsigned DEPTH = rcd_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rcd_pkg::rcd_in_t  cmd_word,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rcd_pkg::rcd_out_t rsp_word
);
    import rcd_pkg::*;

    rcd_ctl_t ctl;
    rcd_sts_t sts;

    // Handshake controller
    rcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Store and pointers
    rcd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_word (cmd_word),
        .rsp_word (rsp_word),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule

// ===== hw/rtl/rcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcd_ctrl
// Handshake controller: sequences command acceptance, the store read of a
// pop and the loading of the response register.
// ----------------------------------------------------------------------------
module rcd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  rcd_pkg::rcd_sts_t sts,
    output rcd_pkg::rcd_ctl_t ctl
);
    import rcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // Response register can take a new word this cycle
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    // Next state and command decode
    always_comb
    begin
        state_next   = state_reg;
        cmd_ready    = 1'b0;
        ctl.accept   = 1'b0;
        ctl.load_imm = 1'b0;
        ctl.load_mem = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready  = rsp_free;
                ctl.accept = cmd_valid && rsp_free;
                if (ctl.accept)
                begin
                    if (sts.pop_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        ctl.load_imm = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                ctl.load_mem = rsp_free;
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid flag
    always_comb
    begin
        if (ctl.load_imm || ctl.load_mem)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // No new word while a pop read is outstanding
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !ctl.accept)
        else $error("command accepted during pop read");

    // A read pop is always followed by the read-data load phase
    a_pop_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept && sts.pop_read |=> state_reg == S_READ)
        else $error("pop read did not enter read phase");

endmodule

// ===== hw/rtl/rcd_datapath.sv =====
// ----------------------------------------------------------------------------
// rcd_datapath
// Byte store, head pointer, fill count, reversal flag and response register.
// ----------------------------------------------------------------------------
module rcd_datapath #(
    parameter int unsigned DEPTH = rcd_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcd_pkg::rcd_in_t  cmd_word,
    output rcd_pkg::rcd_out_t rsp_word,
    input  rcd_pkg::rcd_ctl_t ctl,
    output rcd_pkg::rcd_sts_t sts
);
    import rcd_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    logic [7:0]       byte_store [DEPTH];

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             rev_reg;
    logic             rev_next;
    logic [7:0]       rd_data_reg;
    logic             pend_empty_reg;
    rcd_out_t         rsp_word_reg;

    logic             full;
    logic             empty;
    logic             at_front;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W-1:0] head_inc;
    logic [CNT_W-1:0] back_off;
    logic [SUM_W-1:0] wrap_sum;
    logic [IDX_W-1:0] back_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [1:0]       status_now;
    logic             now_empty;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign at_front = (cmd_word.side == 1'b0) ^ rev_reg;

    // Neighbors of the head with wraparound
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Physical back: one past the last byte for push, the last byte for pop
    assign back_off = (cmd_word.command == CMD_PUSH) ? fill_reg : fill_reg - 1'b1;
    assign wrap_sum = SUM_W'(head_reg) + SUM_W'(back_off);
    assign back_idx = (wrap_sum >= SUM_W'(DEPTH)) ? IDX_W'(wrap_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(wrap_sum);

    assign sts.pop_read = (cmd_word.command == CMD_POP) && !empty;

    // Command execution
    always_comb
    begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        rev_next   = rev_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        status_now = ST_OK;
        unique case (cmd_word.command)
            CMD_PUSH:
            begin
                if (full)
                begin
                    status_now = ST_FULL;
                end
                else
                begin
                    wr_en     = ctl.accept;
                    fill_next = fill_reg + 1'b1;
                    if (at_front)
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                    else
                    begin
                        wr_addr = back_idx;
                    end
                end
            end
            CMD_REVERSE:
            begin
                rev_next = ~rev_reg;
            end
            CMD_POP:
            begin
                if (empty)
                begin
                    status_now = ST_EMPTY;
                end
                else
                begin
                    rd_en     = ctl.accept;
                    fill_next = fill_reg - 1'b1;
                    if (!rev_reg)
                    begin
                        rd_addr   = head_reg;
                        head_next = head_inc;
                    end
                    else
                    begin
                        rd_addr = back_idx;
                    end
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    assign now_empty = (fill_next == '0);

    // Pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            rev_reg  <= 1'b0;
        end
        else if (ctl.accept)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            rev_reg  <= rev_next;
        end
    end

    // Byte store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_store[wr_addr] <= cmd_word.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= byte_store[rd_addr];
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            pend_empty_reg <= now_empty;
        end
        if (ctl.load_imm)
        begin
            rsp_word_reg.out_byte  <= 8'h00;
            rsp_word_reg.status    <= status_now;
            rsp_word_reg.now_empty <= now_empty;
        end
        else if (ctl.load_mem)
        begin
            rsp_word_reg.out_byte  <= rd_data_reg;
            rsp_word_reg.status    <= ST_OK;
            rsp_word_reg.now_empty <= pend_empty_reg;
        end
    end

    assign rsp_word = rsp_word_reg;

    // Fill count bounded by the store size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds depth");

    // Head stays inside the store
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(head_reg) < SUM_W'(DEPTH))
        else $error("head index out of range");

    // A dropped push leaves the sequence untouched
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept && cmd_word.command == CMD_PUSH && full
        |=> $stable(fill_reg) && $stable(head_reg))
        else $error("push into full store changed state");

endmodule

// ===== tb/reversible_char_deque_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reversible_char_deque_test
// Self-checking bench for the reversible byte deque. It drives command words
// over valid/ready and keeps a shadow deque that predicts every response
// word. Responses are matched in order against the predicted words. Idling
// on the command and response sides is varied across phases.
// ----------------------------------------------------------------------------
module reversible_char_deque_test;

    import rcd_pkg::*;

    localparam int unsigned DEPTH      = DEPTH_DEFAULT;
    localparam int unsigned PTR_W      = $clog2(DEPTH);
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          TAIL_WAIT  = 20;
    localparam int          PRINT_CAP  = 100;
    localparam int          MIX_COUNT  = 60;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    rcd_in_t  cmd_word = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    rcd_out_t rsp_word;

    // Shadow copy of the deque
    logic [7:0]     shadow_bytes [DEPTH];
    logic [PTR_W-1:0] shadow_head;
    logic [PTR_W:0]   shadow_fill;
    logic             shadow_reversed;

    rcd_out_t replies_due [$];
    int       mismatch_cnt;
    int       cycle_cnt;
    int       cmd_idle_pct;
    int       rsp_idle_pct;

    reversible_char_deque #(
        .DEPTH(DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_word (cmd_word),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_word (rsp_word)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side backpressure
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_cnt < PRINT_CAP)
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Apply one command word to the shadow deque, return the predicted response
    function automatic rcd_out_t deque_apply(input rcd_in_t w);
        rcd_out_t         r;
        logic [PTR_W-1:0] slot;
        r = '0;
        case (w.command)
            CMD_PUSH:
            begin
                if (shadow_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // logical front is the physical front unless reversed
                    if ((w.side == 1'b0) ^ shadow_reversed)
                    begin
                        shadow_head = shadow_head - 1'b1;
                        shadow_bytes[shadow_head] = w.data_byte;
                    end
                    else
                    begin
                        slot = shadow_head + shadow_fill[PTR_W-1:0];
                        shadow_bytes[slot] = w.data_byte;
                    end
                    shadow_fill++;
                end
            end
            CMD_REVERSE:
                shadow_reversed = ~shadow_reversed;
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (!shadow_reversed)
                    begin
                        r.out_byte  = shadow_bytes[shadow_head];
                        shadow_head = shadow_head + 1'b1;
                    end
                    else
                    begin
                        slot = shadow_head + shadow_fill[PTR_W-1:0] - 1'b1;
                        r.out_byte = shadow_bytes[slot];
                    end
                    shadow_fill--;
                end
            end
            default: ;
        endcase
        r.now_empty = (shadow_fill == 0);
        return r;
    endfunction

    // Response checker
    always @(posedge clk)
    begin
        rcd_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (replies_due.size() == 0)
                report_mismatch("response with nothing outstanding", int'(rsp_word), 0);
            else
            begin
                want = replies_due.pop_front();
                if (rsp_word.out_byte !== want.out_byte)
                    report_mismatch("out_byte", int'(rsp_word.out_byte),
                                    int'(want.out_byte));
                if (rsp_word.status !== want.status)
                    report_mismatch("status", int'(rsp_word.status), int'(want.status));
                if (rsp_word.now_empty !== want.now_empty)
                    report_mismatch("now_empty", int'(rsp_word.now_empty),
                                    int'(want.now_empty));
            end
        end
    end

    function automatic rcd_in_t make_word(input logic [1:0] cmd, input logic side,
                                          input logic [7:0] data);
        rcd_in_t w;
        w.command   = cmd;
        w.side      = side;
        w.data_byte = data;
        return w;
    endfunction

    // Random side and byte for a word
    function automatic logic rand_side();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    // Send one command word; called at a rising edge, returns at its acceptance
    task automatic send_word(input rcd_in_t w);
        if ($urandom_range(99) < cmd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < cmd_idle_pct)
                @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        replies_due.insert(replies_due.size(), deque_apply(w));
    endtask

    // Stop sending and wait until every response is back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic rcd_in_t random_word();
        int pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 45)
            cmd = CMD_PUSH;
        else if (pick < 80)
            cmd = CMD_POP;
        else if (pick < 95)
            cmd = CMD_REVERSE;
        else
            cmd = CMD_UNUSED;
        return make_word(cmd, rand_side(), rand_byte());
    endfunction

    // Edge cases: empty pop, head wrap, both sides, reversal, unused code
    task automatic test_directed();
        send_word(make_word(CMD_POP,     1'b1, 8'hFF));
        send_word(make_word(CMD_REVERSE, 1'b1, 8'hAA));
        send_word(make_word(CMD_REVERSE, 1'b0, 8'h55));
        send_word(make_word(CMD_UNUSED,  1'b1, 8'hFF));
        send_word(make_word(CMD_PUSH,    1'b0, 8'h00));
        send_word(make_word(CMD_PUSH,    1'b1, 8'hFF));
        send_word(make_word(CMD_PUSH,    1'b0, 8'h80));
        send_word(make_word(CMD_POP,     1'b0, 8'h3C));
        send_word(make_word(CMD_REVERSE, 1'b0, 8'h00));
        send_word(make_word(CMD_POP,     1'b1, 8'hFF));
        send_word(make_word(CMD_PUSH,    1'b0, 8'h01));
        send_word(make_word(CMD_PUSH,    1'b1, 8'h7F));
        send_word(make_word(CMD_UNUSED,  1'b0, 8'h00));
        send_word(make_word(CMD_POP,     1'b0, 8'h00));
        send_word(make_word(CMD_REVERSE, 1'b1, 8'hFF));
        send_word(make_word(CMD_POP,     1'b1, 8'h00));
        send_word(make_word(CMD_POP,     1'b0, 8'hFF));
        send_word(make_word(CMD_POP,     1'b0, 8'h00));
        send_word(make_word(CMD_POP,     1'b1, 8'h00));
        send_word(make_word(CMD_PUSH,    1'b1, 8'hA5));
        send_word(make_word(CMD_POP,     1'b0, 8'h00));
        send_word(make_word(CMD_REVERSE, 1'b0, 8'h00));
    endtask

    // Top up to capacity, push into a full store from both ends, step off full
    task automatic test_full_store();
        int need;
        need = int'(DEPTH) - int'(shadow_fill);
        for (int i = 0; i < need; i++)
            send_word(make_word(CMD_PUSH, rand_side(), rand_byte()));
        send_word(make_word(CMD_PUSH, 1'b0, 8'hFF));
        send_word(make_word(CMD_PUSH, 1'b1, 8'h00));
        send_word(make_word(CMD_REVERSE, 1'b0, 8'h00));
        send_word(make_word(CMD_PUSH, rand_side(), rand_byte()));
        send_word(make_word(CMD_POP, 1'b0, 8'h00));
        send_word(make_word(CMD_PUSH, rand_side(), rand_byte()));
        send_word(make_word(CMD_PUSH, rand_side(), rand_byte()));
    endtask

    // Random mix of all commands
    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    initial
    begin
        mismatch_cnt    = 0;
        cycle_cnt       = 0;
        shadow_head     = '0;
        shadow_fill     = '0;
        shadow_reversed = 1'b0;
        cmd_idle_pct    = 31;
        rsp_idle_pct    = 75;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(MIX_COUNT);

        cmd_idle_pct = 75;
        rsp_idle_pct = 31;
        test_full_store();

        cmd_idle_pct = 0;
        rsp_idle_pct = 0;
        test_random_mix(MIX_COUNT);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rcd_pkg.sv
hw/rtl/rcd_ctrl.sv
hw/rtl/rcd_datapath.sv
hw/rtl/reversible_char_deque.sv
tb/reversible_char_deque_test.sv
